// File: hdl/blit_rect_clipper_assert.svh
// assertion macros used by the checker file
`ifndef BLIT_RECT_CLIPPER_ASSERT_SVH
`define BLIT_RECT_CLIPPER_ASSERT_SVH

// same-cycle implication, off while in reset
`define BRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define BRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/brc_pkg.sv
package brc_pkg;

  localparam int FIELD_W = 16;

  typedef enum logic [1:0] {
    STATUS_BLIT   = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_LOCKED = 2'd2
  } status_t;

  localparam logic [1:0] REG_CLIP_X = 2'd0;
  localparam logic [1:0] REG_CLIP_Y = 2'd1;
  localparam logic [1:0] REG_CLIP_W = 2'd2;
  localparam logic [1:0] REG_CLIP_H = 2'd3;

endpackage

// File: hdl/blit_rect_clipper.sv
// blit rectangle clipper: front end of a 2D blitter
// s_* channel takes one request per transfer, m_* channel returns one result
// per request in the same order. the source rectangle is first clipped to the
// source surface (a negative source offset pushes the destination forward),
// then the destination is clipped to the clip rectangle held in the cfg_*
// registers, which the user must write only while no request is in flight;
// the block does not enforce it. four register stages st1 to st4 carry each
// request until its result is ready on m_*. while m_tready stays high, every
// stage takes a new request each cycle, so throughput is one request per cycle.
// each stage has its own valid bit and holds only when the stage after it is
// full and stalled, so bubbles close up while m_tready is low and s_tready
// drops only once every stage is full.
// destination coordinates wrap at COORD_WIDTH bits.
// rst clears all valid bits and the clip registers to zero; nothing in flight
// survives it.
module blit_rect_clipper import brc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [FIELD_W-1:0]  cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  // req_src_x, req_src_y, req_src_w, req_src_h, req_dst_x, req_dst_y, surf_w, surf_h
  input  logic [127:0]        s_tdata,
  // has_src_rect, has_dst_pos, either_locked
  input  logic [2:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // out_src_x, out_src_y, out_dst_x, out_dst_y, out_w, out_h
  output logic [95:0]         m_tdata,
  // status
  output logic [1:0]          m_tuser
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = ((CW > 17) ? CW : 17) + 4;

  typedef logic signed [AW-1:0] wide_t;
  typedef logic [CW-1:0]        coord_t;
  typedef logic [FIELD_W-1:0]   field_t;

  // clip registers
  field_t clip_pos [2];
  field_t clip_len [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_pos[0] <= '0;
      clip_pos[1] <= '0;
      clip_len[0] <= '0;
      clip_len[1] <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CLIP_X: clip_pos[0] <= cfg_data;
        REG_CLIP_Y: clip_pos[1] <= cfg_data;
        REG_CLIP_W: clip_len[0] <= cfg_data;
        REG_CLIP_H: clip_len[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  wide_t c_ext   [2];
  wide_t ccl_ext [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c_ext[a]   = {{(AW-FIELD_W){clip_pos[a][FIELD_W-1]}}, clip_pos[a]};
      ccl_ext[a] = c_ext[a] + wide_t'({{(AW-FIELD_W){1'b0}}, clip_len[a]});
    end
  end

  // stage handshake
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: source clipped to the top-left of the surface
  field_t req_s [2];
  field_t req_l [2];
  field_t req_d [2];
  field_t surf  [2];
  wide_t  s_ext [2];
  wide_t  l_ext [2];
  wide_t  d_ext [2];
  coord_t d_in  [2];
  field_t s1_next   [2];
  wide_t  len1_next [2];
  coord_t dst1_next [2];
  wide_t  lim1_next [2];

  assign req_s[0] = s_tdata[15:0];
  assign req_s[1] = s_tdata[31:16];
  assign req_l[0] = s_tdata[47:32];
  assign req_l[1] = s_tdata[63:48];
  assign req_d[0] = s_tdata[79:64];
  assign req_d[1] = s_tdata[95:80];
  assign surf[0]  = s_tdata[111:96];
  assign surf[1]  = s_tdata[127:112];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s_ext[a] = s_tuser[0] ? {{(AW-FIELD_W){req_s[a][FIELD_W-1]}}, req_s[a]} : '0;
      l_ext[a] = {{(AW-FIELD_W){1'b0}}, (s_tuser[0] ? req_l[a] : surf[a])};
      d_ext[a] = {{(AW-FIELD_W){req_d[a][FIELD_W-1]}}, req_d[a]};
      d_in[a]  = s_tuser[1] ? d_ext[a][CW-1:0] : '0;
      if (s_ext[a][AW-1]) begin
        s1_next[a]   = '0;
        len1_next[a] = l_ext[a] + s_ext[a];
        dst1_next[a] = d_in[a] - s_ext[a][CW-1:0];
      end else begin
        s1_next[a]   = s_ext[a][FIELD_W-1:0];
        len1_next[a] = l_ext[a];
        dst1_next[a] = d_in[a];
      end
      lim1_next[a] = wide_t'({{(AW-FIELD_W){1'b0}}, surf[a]})
                   - wide_t'({{(AW-FIELD_W){1'b0}}, s1_next[a]});
    end
  end

  field_t st1_s   [2];
  wide_t  st1_len [2];
  coord_t st1_dst [2];
  wide_t  st1_lim [2];
  logic   st1_locked;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      st1_s      <= s1_next;
      st1_len    <= len1_next;
      st1_dst    <= dst1_next;
      st1_lim    <= lim1_next;
      st1_locked <= s_tuser[2];
    end
  end

  // stage 2: clip to the surface extent, distance to the left clip edge
  wide_t len2_next [2];
  wide_t d2_next   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      len2_next[a] = (st1_lim[a] < st1_len[a]) ? st1_lim[a] : st1_len[a];
      d2_next[a]   = c_ext[a] - wide_t'({{(AW-CW){st1_dst[a][CW-1]}}, st1_dst[a]});
    end
  end

  field_t st2_s   [2];
  wide_t  st2_len [2];
  coord_t st2_dst [2];
  wide_t  st2_d   [2];
  logic   st2_locked;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      st2_s      <= st1_s;
      st2_len    <= len2_next;
      st2_dst    <= st1_dst;
      st2_d      <= d2_next;
      st2_locked <= st1_locked;
    end
  end

  // stage 3: destination left of the clip edge moves right onto it
  logic   shift3    [2];
  field_t s3_next   [2];
  wide_t  len3_next [2];
  coord_t dst3_next [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      shift3[a] = !st2_d[a][AW-1] && (st2_d[a] != '0);
      if (shift3[a]) begin
        s3_next[a]   = st2_s[a] + st2_d[a][FIELD_W-1:0];
        len3_next[a] = st2_len[a] - st2_d[a];
        dst3_next[a] = c_ext[a][CW-1:0];
      end else begin
        s3_next[a]   = st2_s[a];
        len3_next[a] = st2_len[a];
        dst3_next[a] = st2_dst[a];
      end
    end
  end

  field_t st3_s   [2];
  wide_t  st3_len [2];
  coord_t st3_dst [2];
  logic   st3_locked;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      st3_s      <= s3_next;
      st3_len    <= len3_next;
      st3_dst    <= dst3_next;
      st3_locked <= st2_locked;
    end
  end

  // stage 4: clip to the right/bottom edge and format the result
  wide_t  dst3_ext [2];
  wide_t  lim4     [2];
  wide_t  len4     [2];
  logic   vis4     [2];
  status_t status_next;
  field_t  src_next [2];
  field_t  dst_next [2];
  field_t  len_next [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dst3_ext[a] = {{(AW-CW){st3_dst[a][CW-1]}}, st3_dst[a]};
      lim4[a]     = ccl_ext[a] - dst3_ext[a];
      len4[a]     = (lim4[a] < st3_len[a]) ? lim4[a] : st3_len[a];
      vis4[a]     = (st3_len[a] > 0) && (lim4[a] > 0);
    end
    status_next = STATUS_BLIT;
    for (int a = 0; a < 2; a++) begin
      src_next[a] = st3_s[a];
      dst_next[a] = dst3_ext[a][FIELD_W-1:0];
      len_next[a] = len4[a][FIELD_W-1:0];
    end
    if (st3_locked) begin
      status_next = STATUS_LOCKED;
      for (int a = 0; a < 2; a++) begin
        src_next[a] = '0;
        dst_next[a] = '0;
        len_next[a] = '0;
      end
    end else if (!(vis4[0] && vis4[1])) begin
      status_next = STATUS_EMPTY;
      for (int a = 0; a < 2; a++) begin
        src_next[a] = '0;
        len_next[a] = '0;
      end
    end
  end

  status_t st4_status;
  field_t  st4_src [2];
  field_t  st4_dst [2];
  field_t  st4_len [2];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      st4_status <= status_next;
      st4_src    <= src_next;
      st4_dst    <= dst_next;
      st4_len    <= len_next;
    end
  end

  assign m_tvalid = v4;
  assign m_tuser  = st4_status;
  assign m_tdata  = {st4_len[1], st4_len[0], st4_dst[1], st4_dst[0], st4_src[1], st4_src[0]};

endmodule

// File: hdl/brc_checker.sv
`include "blit_rect_clipper_assert.svh"

module brc_checker import brc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `BRC_ASSERT_NEXT(a_reset_empties, rst, !m_tvalid, "result valid straight after reset")
  `BRC_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready && !rst, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `BRC_ASSERT_IMPL(a_locked_zero, m_tvalid && (m_tuser == STATUS_LOCKED), m_tdata == '0, "locked result carries data")
  `BRC_ASSERT_IMPL(a_empty_zero, m_tvalid && (m_tuser == STATUS_EMPTY), (m_tdata[95:64] == '0) && (m_tdata[31:0] == '0), "empty result has size or source")
  `BRC_ASSERT_IMPL(a_blit_size, m_tvalid && (m_tuser == STATUS_BLIT), (m_tdata[79:64] != '0) && (m_tdata[95:80] != '0), "blit result with zero size")

endmodule

bind blit_rect_clipper brc_checker u_brc_checker (.*);

// File: sim/blit_rect_clipper_tb.sv
`timescale 1ns / 100ps

module blit_rect_clipper_tb;
  import brc_pkg::*;

  localparam int LATENCY = 4;
  localparam int LONG_HOLD = 40;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic        has_src;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] src_w;
    logic [15:0] src_h;
    logic        has_dst;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic [15:0] surf_w;
    logic [15:0] surf_h;
    logic        locked;
  } blit_request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic [15:0] w;
    logic [15:0] h;
  } clip_result_t;

  class clip_predictor;
    logic [15:0]  clip_x, clip_y, clip_w, clip_h;
    clip_result_t pending_results[$];
    int errors, requests, checked, n_blit, n_empty, n_locked;

    function new();
      clip_x = '0;
      clip_y = '0;
      clip_w = '0;
      clip_h = '0;
    endfunction

    function void set_clip(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_CLIP_X: clip_x = val;
        REG_CLIP_Y: clip_y = val;
        REG_CLIP_W: clip_w = val;
        REG_CLIP_H: clip_h = val;
      endcase
    endfunction

    function longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
    endfunction

    // one axis: clip source to surface, then destination to the clip window
    function longint clip_span(logic has_src, logic [15:0] rs, logic [15:0] rl,
                               logic [15:0] surf, logic [15:0] cpos,
                               logic [15:0] clen, output longint src_o,
                               inout longint dst);
      longint s, len, d, sz, c, cl;
      sz = surf;
      c = longint'($signed(cpos));
      cl = clen;
      if (has_src) begin
        s = longint'($signed(rs));
        len = rl;
        if (s < 0) begin
          len += s;
          dst = wrap16(dst - s);
          s = 0;
        end
        if (sz - s < len) len = sz - s;
      end else begin
        s = 0;
        len = sz;
      end
      d = c - dst;
      if (d > 0) begin
        len -= d;
        dst = wrap16(dst + d);
        s += d;
      end
      d = dst + len - c - cl;
      if (d > 0) len -= d;
      src_o = s;
      return len;
    endfunction

    function clip_result_t predict(blit_request_t r);
      clip_result_t o;
      longint dx, dy, sx, sy, w, h;
      o = '0;
      if (r.locked) begin
        o.status = STATUS_LOCKED;
        return o;
      end
      dx = r.has_dst ? longint'($signed(r.dst_x)) : 64'sd0;
      dy = r.has_dst ? longint'($signed(r.dst_y)) : 64'sd0;
      w = clip_span(r.has_src, r.src_x, r.src_w, r.surf_w, clip_x, clip_w, sx, dx);
      h = clip_span(r.has_src, r.src_y, r.src_h, r.surf_h, clip_y, clip_h, sy, dy);
      o.dst_x = dx[15:0];
      o.dst_y = dy[15:0];
      if (w > 0 && h > 0) begin
        o.status = STATUS_BLIT;
        o.src_x = sx[15:0];
        o.src_y = sy[15:0];
        o.w = w[15:0];
        o.h = h[15:0];
      end else begin
        o.status = STATUS_EMPTY;
      end
      return o;
    endfunction

    function void note_request(blit_request_t r);
      clip_result_t p;
      p = predict(r);
      requests++;
      case (p.status)
        STATUS_BLIT:  n_blit++;
        STATUS_EMPTY: n_empty++;
        default:      n_locked++;
      endcase
      pending_results.push_back(p);
    endfunction

    function void compare_field(string tag, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
      end
    endfunction

    function void check_result(clip_result_t got);
      clip_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("status", {14'd0, want.status}, {14'd0, got.status});
      compare_field("out_src_x", want.src_x, got.src_x);
      compare_field("out_src_y", want.src_y, got.src_y);
      compare_field("out_dst_x", want.dst_x, got.dst_x);
      compare_field("out_dst_y", want.dst_y, got.dst_y);
      compare_field("out_w", want.w, got.w);
      compare_field("out_h", want.h, got.h);
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          cfg_wen;
  logic [1:0]    cfg_index;
  logic [15:0]   cfg_data;
  logic          s_tvalid;
  logic          s_tready;
  // req_src_x, req_src_y, req_src_w, req_src_h, req_dst_x, req_dst_y, surf_w, surf_h
  logic [127:0]  s_tdata;
  // has_src_rect, has_dst_pos, either_locked
  logic [2:0]    s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  // out_src_x, out_src_y, out_dst_x, out_dst_y, out_w, out_h
  logic [95:0]   m_tdata;
  // status
  logic [1:0]    m_tuser;

  clip_predictor clip_model = new();
  bit no_gaps;
  bit hold_request;
  int clip_settings;

  blit_rect_clipper dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    int stall;
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    clip_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.src_x = m_tdata[15:0];
      got.src_y = m_tdata[31:16];
      got.dst_x = m_tdata[47:32];
      got.dst_y = m_tdata[63:48];
      got.w = m_tdata[79:64];
      got.h = m_tdata[95:80];
      clip_model.check_result(got);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(blit_request_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      if (s_tvalid) s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.surf_h, r.surf_w, r.dst_y, r.dst_x, r.src_h, r.src_w, r.src_y, r.src_x};
    s_tuser <= {r.locked, r.has_dst, r.has_src};
    do @(posedge clk); while (!s_tready);
    clip_model.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_fields(int hs, logic [15:0] sx, logic [15:0] sy,
                             logic [15:0] sw, logic [15:0] sh, int hd,
                             logic [15:0] dx, logic [15:0] dy,
                             logic [15:0] fw, logic [15:0] fh, int lk);
    blit_request_t r;
    r = '{hs[0], sx, sy, sw, sh, hd[0], dx, dy, fw, fh, lk[0]};
    send_request(r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (clip_model.pending_results.size() != 0);
  endtask

  task automatic program_clip(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                              logic [15:0] h);
    logic [15:0] vals [4];
    vals = '{x, y, w, h};
    for (int i = 0; i < 4; i++) begin
      cfg_wen <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      clip_model.set_clip(i[1:0], vals[i]);
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
    clip_settings++;
  endtask

  // mostly near the clip window so that real blits come out
  function automatic logic [15:0] rand_pos();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom);
      1: v = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: v = 16'(int'($urandom_range(0, 800)) - 100);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_len();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom);
      1: v = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: v = 16'($urandom_range(0, 700));
    endcase
    return v;
  endfunction

  function automatic blit_request_t rand_request();
    blit_request_t r;
    r.has_src = $urandom_range(0, 3) != 0;
    r.src_x = rand_pos();
    r.src_y = rand_pos();
    r.src_w = rand_len();
    r.src_h = rand_len();
    r.has_dst = $urandom_range(0, 3) != 0;
    r.dst_x = rand_pos();
    r.dst_y = rand_pos();
    r.surf_w = rand_len();
    r.surf_h = rand_len();
    r.locked = $urandom_range(0, 9) == 0;
    return r;
  endfunction

  initial begin
    logic [15:0] cx, cy, cw, ch;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    clip_settings = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // clip window still empty from reset
    send_fields(1, 16'd0, 16'd0, 16'd10, 16'd10, 1, 16'd0, 16'd0, 16'd50, 16'd50, 0);
    send_fields(0, 16'd0, 16'd0, 16'd0, 16'd0, 0, 16'd0, 16'd0, 16'd100, 16'd100, 0);
    wait_drained();

    program_clip(16'd10, 16'd20, 16'd300, 16'd200);
    send_fields(1, 16'd5, 16'd5, 16'd50, 16'd40, 1, 16'd50, 16'd60, 16'd200, 16'd200, 1);
    send_fields(0, 16'd0, 16'd0, 16'd0, 16'd0, 0, 16'd0, 16'd0, 16'd100, 16'd80, 0);
    send_fields(1, 16'd5, 16'd5, 16'd50, 16'd40, 1, 16'd50, 16'd60, 16'd200, 16'd200, 0);
    // negative source offset pushes the destination forward
    send_fields(1, -16'd20, -16'd10, 16'd60, 16'd50, 1, 16'd100, 16'd100,
                16'd200, 16'd200, 0);
    // source origin past the surface
    send_fields(1, 16'd300, 16'd10, 16'd20, 16'd20, 1, 16'd50, 16'd50, 16'd200, 16'd200, 0);
    // destination right of the window, then straddling its far corner
    send_fields(1, 16'd0, 16'd0, 16'd50, 16'd50, 1, 16'd500, 16'd100, 16'd200, 16'd200, 0);
    send_fields(1, 16'd0, 16'd0, 16'd50, 16'd50, 1, 16'd280, 16'd190, 16'd200, 16'd200, 0);
    // destination shift wraps
    send_fields(1, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 1, 16'h7fff, 16'h7fff,
                16'hffff, 16'hffff, 0);
    send_fields(1, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 1, 16'h8000, 16'h8000,
                16'hffff, 16'hffff, 0);
    send_fields(1, 16'd0, 16'd0, 16'd0, 16'd0, 1, 16'd20, 16'd30, 16'd100, 16'd100, 0);
    send_fields(0, 16'd0, 16'd0, 16'd0, 16'd0, 1, 16'd20, 16'd30, 16'd0, 16'd0, 0);
    send_fields(0, 16'd0, 16'd0, 16'd0, 16'd0, 1, 16'h8000, 16'h8000,
                16'hffff, 16'hffff, 0);
    // fields that the flags say to ignore, then requests with both flags set
    send_fields(1, 16'd3, 16'd4, 16'd30, 16'd30, 0, 16'h1234, 16'hfedc, 16'd100, 16'd100, 0);
    send_fields(0, 16'h8765, 16'h4321, 16'hffff, 16'd7, 1, 16'd40, 16'd40,
                16'd60, 16'd60, 0);
    send_fields(0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 16'hffff, 16'hffff,
                16'hffff, 16'hffff, 1);
    send_fields(1, 16'd10, 16'd10, 16'd100, 16'd100, 1, 16'h8000, 16'h7fff,
                16'd400, 16'd400, 0);
    send_fields(1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 16'hffff, 16'hffff,
                16'hffff, 16'hffff, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: program_clip(16'h8000, 16'h8000, 16'hffff, 16'hffff);
        1: program_clip(16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
        2: program_clip(16'h0000, 16'h0000, 16'hffff, 16'hffff);
        default: begin
          cx = 16'(int'($urandom_range(0, 350)) - 50);
          cy = 16'(int'($urandom_range(0, 350)) - 50);
          cw = 16'($urandom_range(0, 700));
          ch = 16'($urandom_range(0, 700));
          program_clip(cx, cy, cw, ch);
        end
      endcase
      // two stretches without idling, the second of which also holds the output off
      no_gaps = (phase == 3) || (phase == 5);
      if (phase == 5) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_request(rand_request());
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (LATENCY + 4) @(negedge clk);
    $display("covered %0d requests over %0d clip settings, with a %0d-cycle output hold",
             clip_model.requests, clip_settings, LONG_HOLD);
    $display("results checked: %0d (%0d blit, %0d empty, %0d locked)",
             clip_model.checked, clip_model.n_blit, clip_model.n_empty, clip_model.n_locked);
    if (clip_model.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/brc_pkg.sv
hdl/blit_rect_clipper.sv
hdl/brc_checker.sv
sim/blit_rect_clipper_tb.sv
